// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

    // Field and register widths.
    localparam int C_WIDE_BITS   = 20;
    localparam int C_NARROW_BITS = 16;
    localparam int SCALE_BITS    = 23;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 23;
    localparam int OUT_BITS      = 32;
    localparam int QUOT_BITS     = 32;

    // Parameter defaults.
    localparam int DEF_OUT_FRAC_BITS = 6;
    localparam int DEF_RAW_BITS      = 24;

    // Scale register value after reset.
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 23'd1572864;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int PIPE_LATENCY = 41;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_OFFSET     = 3'd0,
        REG_PRESS_LIN  = 3'd1,
        REG_TEMP_LIN   = 3'd2,
        REG_CROSS_LIN  = 3'd3,
        REG_PRESS_SQ   = 3'd4,
        REG_CROSS_SQ   = 3'd5,
        REG_PRESS_CUBE = 3'd6,
        REG_SCALE      = 3'd7
    } cfg_reg_t;

endpackage

// ===== hw/rtl/bpc_wmul.sv =====
// Two-stage signed multiplier built from four narrower partial products.
module bpc_wmul #(
    parameter int AW = 48,
    parameter int BW = 48
) (
    input  logic                 clk,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [AW+BW-1:0] p
);
    localparam int ALW = AW / 2;
    localparam int AHW = AW - ALW;
    localparam int BLW = BW / 2;
    localparam int BHW = BW - BLW;
    localparam int PW  = AW + BW;

    logic signed [AHW-1:0] a_hi;
    logic signed [ALW:0]   a_lo;
    logic signed [BHW-1:0] b_hi;
    logic signed [BLW:0]   b_lo;

    logic signed [AHW+BHW-1:0]   hh_reg;
    logic signed [AHW+BLW:0]     hl_reg;
    logic signed [ALW+BHW:0]     lh_reg;
    logic signed [ALW+BLW+1:0]   ll_reg;
    logic signed [PW-1:0]        p_reg;

    // Split each operand into a signed upper half and an unsigned lower half.
    assign a_hi = $signed(a[AW-1:ALW]);
    assign a_lo = $signed({1'b0, a[ALW-1:0]});
    assign b_hi = $signed(b[BW-1:BLW]);
    assign b_lo = $signed({1'b0, b[BLW-1:0]});

    // First stage: partial products.
    always_ff @(posedge clk)
    begin
        hh_reg <= a_hi * b_hi;
        hl_reg <= a_hi * b_lo;
        lh_reg <= a_lo * b_hi;
        ll_reg <= a_lo * b_lo;
    end

    // Second stage: weighted sum of the partial products.
    always_ff @(posedge clk)
    begin
        p_reg <= (PW'(hh_reg) <<< (ALW + BLW)) + (PW'(hl_reg) <<< ALW)
               + (PW'(lh_reg) <<< BLW) + PW'(ll_reg);
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/bpc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, MSB first.
module bpc_div #(
    parameter int NUMW  = 104,
    parameter int DENW  = 70,
    parameter int QW    = 32,
    parameter int SIDEW = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUMW-1:0]  in_num,
    input  logic [DENW-1:0]  in_den,
    input  logic [SIDEW-1:0] in_side,
    output logic             out_valid,
    output logic [QW-1:0]    out_quot,
    output logic [SIDEW-1:0] out_side
);
    localparam int CW = NUMW + QW;

    logic [NUMW-1:0]  st_rem  [QW+1];
    logic [DENW-1:0]  st_den  [QW+1];
    logic [QW-1:0]    st_quot [QW+1];
    logic [SIDEW-1:0] st_side [QW+1];
    logic             st_vld  [QW+1];

    assign st_rem[0]  = in_num;
    assign st_den[0]  = in_den;
    assign st_quot[0] = '0;
    assign st_side[0] = in_side;
    assign st_vld[0]  = in_valid;

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int BIT = QW - 1 - j;

        logic [CW-1:0]    dsh;
        logic [CW-1:0]    rem_ext;
        logic             fits;
        logic [QW-1:0]    quot_next;
        logic [NUMW-1:0]  rem_next;
        logic [NUMW-1:0]  rem_reg;
        logic [DENW-1:0]  den_reg;
        logic [QW-1:0]    quot_reg;
        logic [SIDEW-1:0] side_reg;
        logic             vld_reg;

        // Trial subtract of the shifted divisor.
        assign dsh     = CW'(st_den[j]) << BIT;
        assign rem_ext = CW'(st_rem[j]);
        assign fits    = (rem_ext >= dsh);

        always_comb
        begin
            quot_next      = st_quot[j];
            quot_next[BIT] = fits;
            rem_next       = fits ? NUMW'(rem_ext - dsh) : st_rem[j];
        end

        always_ff @(posedge clk)
        begin
            rem_reg  <= rem_next;
            den_reg  <= st_den[j];
            quot_reg <= quot_next;
            side_reg <= st_side[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else
            begin
                vld_reg <= st_vld[j];
            end
        end

        assign st_rem[j+1]  = rem_reg;
        assign st_den[j+1]  = den_reg;
        assign st_quot[j+1] = quot_reg;
        assign st_side[j+1] = side_reg;
        assign st_vld[j+1]  = vld_reg;
    end

    assign out_valid = st_vld[QW];
    assign out_quot  = st_quot[QW];
    assign out_side  = st_side[QW];

endmodule

// ===== hw/rtl/baro_pressure_compensation.sv =====
// Barometric pressure compensation.
// Input: raise start with pressure_raw and temperature_raw; a sample is taken
// at every rising edge where start is high and busy is low. busy stays low,
// so a new sample may be given in every cycle.
// Configuration: wr_en, wr_index and wr_data write one coefficient or the
// scale register at a rising edge. Write only while no sample is in flight.
// Output: result_valid is high for one cycle with pressure_pa_q6 (pascals
// with OUT_FRAC_BITS fraction bits, rounded half away from zero, clamped to
// 32 bits) and saturated. The receiver cannot stall, so results are simply
// presented and must be captured in that cycle.
// Pipeline: throughput is one sample per cycle. Eight stages of products,
// sums, magnitude, rounding offset and overflow flag feed the 32-stage
// restoring divider (one quotient bit per stage), which is followed by
// the output register.
// Reset: clears all valid bits, so no result is shown until a sample
// arrives, and sets the coefficients to zero and the scale to its default.
module baro_pressure_compensation #(
    parameter int OUT_FRAC_BITS = bpc_pkg::DEF_OUT_FRAC_BITS,
    parameter int RAW_BITS      = bpc_pkg::DEF_RAW_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [RAW_BITS-1:0]         pressure_raw,
    input  logic signed [RAW_BITS-1:0]         temperature_raw,
    input  logic                               wr_en,
    input  logic [bpc_pkg::CFG_IDX_BITS-1:0]   wr_index,
    input  logic [bpc_pkg::CFG_DATA_BITS-1:0]  wr_data,
    output logic                               result_valid,
    output logic signed [bpc_pkg::OUT_BITS-1:0] pressure_pa_q6,
    output logic                               saturated
);
    import bpc_pkg::*;

    localparam int KW   = SCALE_BITS + 1;
    localparam int SW   = (RAW_BITS > KW) ? RAW_BITS : KW;
    localparam int P1W  = C_WIDE_BITS + SW;
    localparam int DW   = C_NARROW_BITS + SW;
    localparam int AW   = P1W + 2;
    localparam int BW   = DW + 1;
    localparam int QW2  = 2 * SW;
    localparam int PAW  = AW + QW2;
    localparam int PBW  = BW + QW2;
    localparam int NW   = PAW + 2;
    localparam int NFW  = NW + OUT_FRAC_BITS;
    localparam int K3W  = 3 * SCALE_BITS;
    localparam int NUMW = NFW + 1;
    localparam int DENW = K3W + 1;
    localparam int EXTW = NUMW + QUOT_BITS;

    // Configuration registers.
    logic signed [C_WIDE_BITS-1:0]   coef_offset_reg;
    logic signed [C_WIDE_BITS-1:0]   coef_press_lin_reg;
    logic signed [C_NARROW_BITS-1:0] coef_temp_lin_reg;
    logic signed [C_NARROW_BITS-1:0] coef_cross_lin_reg;
    logic signed [C_NARROW_BITS-1:0] coef_press_sq_reg;
    logic signed [C_NARROW_BITS-1:0] coef_cross_sq_reg;
    logic signed [C_NARROW_BITS-1:0] coef_press_cube_reg;
    logic [SCALE_BITS-1:0]           raw_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_offset_reg     <= '0;
            coef_press_lin_reg  <= '0;
            coef_temp_lin_reg   <= '0;
            coef_cross_lin_reg  <= '0;
            coef_press_sq_reg   <= '0;
            coef_cross_sq_reg   <= '0;
            coef_press_cube_reg <= '0;
            raw_scale_reg       <= SCALE_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_OFFSET:     coef_offset_reg     <= wr_data[C_WIDE_BITS-1:0];
                REG_PRESS_LIN:  coef_press_lin_reg  <= wr_data[C_WIDE_BITS-1:0];
                REG_TEMP_LIN:   coef_temp_lin_reg   <= wr_data[C_NARROW_BITS-1:0];
                REG_CROSS_LIN:  coef_cross_lin_reg  <= wr_data[C_NARROW_BITS-1:0];
                REG_PRESS_SQ:   coef_press_sq_reg   <= wr_data[C_NARROW_BITS-1:0];
                REG_CROSS_SQ:   coef_cross_sq_reg   <= wr_data[C_NARROW_BITS-1:0];
                REG_PRESS_CUBE: coef_press_cube_reg <= wr_data[C_NARROW_BITS-1:0];
                REG_SCALE:      raw_scale_reg       <= wr_data[SCALE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Input transfer; the pipeline never stalls.
    logic in_fire;
    assign busy    = 1'b0;
    assign in_fire = start && !busy;

    // Valid bits for the eight stages ahead of the divider.
    logic [7:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[6:0], in_fire};
        end
    end

    // A zero scale acts as one.
    logic [SCALE_BITS-1:0] k_eff;
    logic signed [KW-1:0]  ks;
    assign k_eff = (raw_scale_reg == '0) ? SCALE_BITS'(1) : raw_scale_reg;
    assign ks    = $signed({1'b0, k_eff});

    // Stage 1: first-level products.
    logic signed [C_WIDE_BITS+KW-1:0]         m_off;
    logic signed [C_WIDE_BITS+RAW_BITS-1:0]   m_plin;
    logic signed [C_NARROW_BITS+RAW_BITS-1:0] m_tlin;
    logic signed [C_NARROW_BITS+RAW_BITS-1:0] m_xlin;
    logic signed [C_NARROW_BITS+RAW_BITS-1:0] m_psq;
    logic signed [C_NARROW_BITS+RAW_BITS-1:0] m_xsq;
    logic signed [C_NARROW_BITS+RAW_BITS-1:0] m_pcub;
    logic signed [2*KW-1:0]                   m_kk;
    logic signed [RAW_BITS+KW-1:0]            m_pk;
    logic signed [2*RAW_BITS-1:0]             m_pp;

    assign m_off  = coef_offset_reg * ks;
    assign m_plin = coef_press_lin_reg * pressure_raw;
    assign m_tlin = coef_temp_lin_reg * temperature_raw;
    assign m_xlin = coef_cross_lin_reg * temperature_raw;
    assign m_psq  = coef_press_sq_reg * pressure_raw;
    assign m_xsq  = coef_cross_sq_reg * temperature_raw;
    assign m_pcub = coef_press_cube_reg * pressure_raw;
    assign m_kk   = ks * ks;
    assign m_pk   = pressure_raw * ks;
    assign m_pp   = pressure_raw * pressure_raw;

    logic signed [P1W-1:0] s1_a_reg, s1_b_reg, s1_c_reg;
    logic signed [DW-1:0]  s1_d_reg, s1_e_reg, s1_f_reg, s1_g_reg;
    logic signed [QW2-1:0] s1_k2_reg, s1_pk_reg, s1_pp_reg;
    logic signed [KW-1:0]  s1_k_reg;

    always_ff @(posedge clk)
    begin
        s1_a_reg  <= P1W'(m_off);
        s1_b_reg  <= P1W'(m_plin);
        s1_c_reg  <= P1W'(m_tlin);
        s1_d_reg  <= DW'(m_psq);
        s1_e_reg  <= DW'(m_xlin);
        s1_f_reg  <= DW'(m_pcub);
        s1_g_reg  <= DW'(m_xsq);
        s1_k2_reg <= QW2'(m_kk);
        s1_pk_reg <= QW2'(m_pk);
        s1_pp_reg <= QW2'(m_pp);
        s1_k_reg  <= ks;
    end

    // Stage 2: group terms as k^2*A + p*k*B + p^2*C.
    logic signed [AW-1:0]  s2_a_reg;
    logic signed [BW-1:0]  s2_b_reg, s2_c_reg;
    logic signed [QW2-1:0] s2_k2_reg, s2_pk_reg, s2_pp_reg;
    logic signed [KW-1:0]  s2_k_reg;

    always_ff @(posedge clk)
    begin
        s2_a_reg  <= AW'(s1_a_reg) + AW'(s1_b_reg) + AW'(s1_c_reg);
        s2_b_reg  <= BW'(s1_d_reg) + BW'(s1_e_reg);
        s2_c_reg  <= BW'(s1_f_reg) + BW'(s1_g_reg);
        s2_k2_reg <= s1_k2_reg;
        s2_pk_reg <= s1_pk_reg;
        s2_pp_reg <= s1_pp_reg;
        s2_k_reg  <= s1_k_reg;
    end

    // Stages 3 and 4: wide products and the divisor k^3.
    logic signed [PAW-1:0]    prod_a;
    logic signed [PBW-1:0]    prod_b, prod_c;
    logic signed [QW2+KW-1:0] prod_k3;

    bpc_wmul #(.AW(AW), .BW(QW2)) u_mul_a (
        .clk (clk), .a (s2_a_reg), .b (s2_k2_reg), .p (prod_a)
    );
    bpc_wmul #(.AW(BW), .BW(QW2)) u_mul_b (
        .clk (clk), .a (s2_b_reg), .b (s2_pk_reg), .p (prod_b)
    );
    bpc_wmul #(.AW(BW), .BW(QW2)) u_mul_c (
        .clk (clk), .a (s2_c_reg), .b (s2_pp_reg), .p (prod_c)
    );
    bpc_wmul #(.AW(QW2), .BW(KW)) u_mul_k3 (
        .clk (clk), .a (s2_k2_reg), .b (s2_k_reg), .p (prod_k3)
    );

    // Stage 5: numerator sum, scaled by the output fraction bits.
    logic signed [NW-1:0]  n_sum;
    logic signed [NFW-1:0] s5_nf_reg;
    logic [K3W-1:0]        s5_k3_reg;

    assign n_sum = NW'(prod_a) + NW'(prod_b) + NW'(prod_c);

    always_ff @(posedge clk)
    begin
        s5_nf_reg <= NFW'(n_sum) <<< OUT_FRAC_BITS;
        s5_k3_reg <= prod_k3[K3W-1:0];
    end

    // Stage 6: sign and magnitude.
    logic [NFW-1:0] s6_mag_reg;
    logic           s6_neg_reg;
    logic [K3W-1:0] s6_k3_reg;

    always_ff @(posedge clk)
    begin
        s6_neg_reg <= s5_nf_reg[NFW-1];
        s6_mag_reg <= s5_nf_reg[NFW-1] ? NFW'(-s5_nf_reg) : NFW'(s5_nf_reg);
        s6_k3_reg  <= s5_k3_reg;
    end

    // Stage 7: rounding numerator 2|N| + D and divisor 2D.
    logic [NUMW-1:0] s7_num_reg;
    logic [DENW-1:0] s7_den_reg;
    logic            s7_neg_reg;

    always_ff @(posedge clk)
    begin
        s7_num_reg <= (NUMW'(s6_mag_reg) << 1) + NUMW'(s6_k3_reg);
        s7_den_reg <= {s6_k3_reg, 1'b0};
        s7_neg_reg <= s6_neg_reg;
    end

    // Stage 8: flag quotients that cannot fit in the quotient width.
    logic [NUMW-1:0] s8_num_reg;
    logic [DENW-1:0] s8_den_reg;
    logic            s8_neg_reg;
    logic            s8_big_reg;

    always_ff @(posedge clk)
    begin
        s8_num_reg <= s7_num_reg;
        s8_den_reg <= s7_den_reg;
        s8_neg_reg <= s7_neg_reg;
        s8_big_reg <= (EXTW'(s7_num_reg) >= (EXTW'(s7_den_reg) << QUOT_BITS));
    end

    // Divider.
    logic                 div_valid;
    logic [QUOT_BITS-1:0] div_quot;
    logic [1:0]           div_side;

    bpc_div #(
        .NUMW  (NUMW),
        .DENW  (DENW),
        .QW    (QUOT_BITS),
        .SIDEW (2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[7]),
        .in_num    (s8_num_reg),
        .in_den    (s8_den_reg),
        .in_side   ({s8_neg_reg, s8_big_reg}),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // Output stage: clamp, restore sign.
    logic                 q_neg, q_over, q_sat;
    logic [OUT_BITS-1:0]  q_limit;
    logic [OUT_BITS-1:0]  q_val;

    assign q_neg   = div_side[1];
    assign q_limit = q_neg ? {1'b1, {(OUT_BITS-1){1'b0}}} : {1'b0, {(OUT_BITS-1){1'b1}}};
    assign q_over  = q_neg ? (div_quot[OUT_BITS-1] && (div_quot[OUT_BITS-2:0] != '0))
                           : div_quot[OUT_BITS-1];
    assign q_sat   = div_side[0] || q_over;
    assign q_val   = q_sat ? q_limit : (q_neg ? OUT_BITS'(-div_quot) : div_quot);

    logic                result_valid_reg;
    logic [OUT_BITS-1:0] pressure_reg;
    logic                saturated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pressure_reg  <= q_val;
        saturated_reg <= q_sat;
    end

    assign result_valid   = result_valid_reg;
    assign pressure_pa_q6 = $signed(pressure_reg);
    assign saturated      = saturated_reg;

endmodule

// ===== hw/rtl/bpc_checker.sv =====
// Port-level checks for the compensation pipeline.
module bpc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              result_valid,
    input logic signed [bpc_pkg::OUT_BITS-1:0] pressure_pa_q6,
    input logic                              saturated
);
    import bpc_pkg::*;

    // Every result comes from a transfer a fixed latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, PIPE_LATENCY))
        else $error("result without a matching input transfer");

    // Every input transfer yields a result after the fixed latency.
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY result_valid)
        else $error("input transfer produced no result");

    // A clamped result sits at one of the two range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            (pressure_pa_q6 == 32'sh7FFF_FFFF || pressure_pa_q6 == 32'sh8000_0000))
        else $error("saturated result is not at a range limit");

endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (.*);

// ===== tb/sv/baro_pressure_compensation_test.sv =====
`timescale 1ns / 100ps

module baro_pressure_compensation_test;
    import bpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic signed [23:0] press;
        logic signed [23:0] temp;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pa_q6;
        logic               sat;
    } comp_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [23:0] pressure_raw;
    logic signed [23:0] temperature_raw;
    logic wr_en;
    logic [CFG_IDX_BITS-1:0] wr_index;
    logic [CFG_DATA_BITS-1:0] wr_data;
    logic result_valid;
    logic signed [31:0] pressure_pa_q6;
    logic saturated;

    baro_pressure_compensation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pressure_raw(pressure_raw), .temperature_raw(temperature_raw),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .result_valid(result_valid), .pressure_pa_q6(pressure_pa_q6),
        .saturated(saturated)
    );

    // Local copy of the calibration registers.
    logic [CFG_DATA_BITS-1:0] coef_shadow [8];

    sample_t pending_samples[$];
    comp_t   expected_pressures[$];
    int      idle_percent;
    int      error_count;
    int      watchdog;
    int      transfers_in;
    int      transfers_out;
    int      sat_seen;

    // Compensated pressure from the shadow registers, exact integer arithmetic.
    function automatic comp_t compensate(sample_t s);
        logic signed [255:0] p, t, k, c00, c10, c01, c11, c20, c21, c30;
        logic signed [255:0] n, mag, den, q;
        logic neg;
        comp_t r;
        p   = s.press;
        t   = s.temp;
        c00 = $signed(coef_shadow[REG_OFFSET][19:0]);
        c10 = $signed(coef_shadow[REG_PRESS_LIN][19:0]);
        c01 = $signed(coef_shadow[REG_TEMP_LIN][15:0]);
        c11 = $signed(coef_shadow[REG_CROSS_LIN][15:0]);
        c20 = $signed(coef_shadow[REG_PRESS_SQ][15:0]);
        c21 = $signed(coef_shadow[REG_CROSS_SQ][15:0]);
        c30 = $signed(coef_shadow[REG_PRESS_CUBE][15:0]);
        k   = $signed({1'b0, coef_shadow[REG_SCALE]});
        if (k == 0)
            k = 1;
        n = c00*k*k*k + c10*p*k*k + c20*p*p*k + c30*p*p*p + c01*t*k*k
            + c11*t*p*k + c21*t*p*p;
        n = n * 64;
        neg = n < 0;
        mag = neg ? -n : n;
        den = k*k*k;
        q = (2*mag + den) / (2*den);
        if (!neg && q > 256'sd2147483647)
        begin
            r.pa_q6 = 32'h7FFFFFFF;
            r.sat = 1'b1;
        end
        else if (neg && q > 256'sd2147483648)
        begin
            r.pa_q6 = 32'h80000000;
            r.sat = 1'b1;
        end
        else
        begin
            r.pa_q6 = neg ? -q[31:0] : q[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: pops pending samples, idling at random by phase.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            pressure_raw <= '0;
            temperature_raw <= '0;
        end
        else if (!(start && busy))
        begin
            if (start)
            begin
                expected_pressures.push_back(compensate({pressure_raw, temperature_raw}));
                transfers_in++;
            end
            if (pending_samples.size() > 0 && $urandom_range(99) >= idle_percent)
            begin
                sample_t s;
                s = pending_samples.pop_front();
                start <= 1'b1;
                pressure_raw <= s.press;
                temperature_raw <= s.temp;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: checks every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            comp_t e;
            transfers_out++;
            if (expected_pressures.size() == 0)
            begin
                $error("unexpected result %0d", pressure_pa_q6);
                error_count++;
            end
            else
            begin
                e = expected_pressures.pop_front();
                if (saturated)
                    sat_seen++;
                if (pressure_pa_q6 !== e.pa_q6)
                begin
                    $error("pressure_pa_q6: expected %0d, got %0d", e.pa_q6, pressure_pa_q6);
                    error_count++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated: expected %0b, got %0b", e.sat, saturated);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            watchdog <= 0;
        else
            watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_LIMIT)
        begin
            $display("timeout");
            $display("TB_ERROR");
            $finish;
        end
    end

    // Waits until every queued sample has been checked, plus the pipeline depth.
    task automatic drain();
        while (pending_samples.size() > 0 || start || expected_pressures.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        coef_shadow[idx] = val;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [23:0] rand_raw();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom_range(255));
            3: return 24'(-$urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_coef(int bits);
        logic [CFG_DATA_BITS-1:0] v;
        case ($urandom_range(4))
            0: v = CFG_DATA_BITS'(1 << (bits - 1));
            1: v = CFG_DATA_BITS'((1 << (bits - 1)) - 1);
            2: v = '0;
            default: v = CFG_DATA_BITS'($urandom);
        endcase
        return v & CFG_DATA_BITS'((1 << bits) - 1);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] rand_scale();
        case ($urandom_range(5))
            0: return 23'd1;
            1: return 23'h7FFFFF;
            2: return SCALE_RESET;
            3: return CFG_DATA_BITS'($urandom_range(2, 4000));
            default: return CFG_DATA_BITS'($urandom_range(1, 23'h7FFFFF));
        endcase
    endfunction

    // Stimulus.
    initial
    begin
        int idles[4] = '{0, 48, 0, 29};
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        idle_percent = 0;
        error_count = 0;
        watchdog = 0;
        transfers_in = 0;
        transfers_out = 0;
        sat_seen = 0;
        for (int i = 0; i < 8; i++)
            coef_shadow[i] = '0;
        coef_shadow[REG_SCALE] = SCALE_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults, then extreme coefficients and tiny scales.
        pending_samples.push_back('{24'sh7FFFFF, 24'sh800000});
        drain();
        write_reg(REG_OFFSET, 23'h0A0000);
        write_reg(REG_PRESS_LIN, 23'h080000);
        write_reg(REG_TEMP_LIN, 23'h008000);
        write_reg(REG_CROSS_LIN, 23'h007FFF);
        write_reg(REG_PRESS_SQ, 23'h008000);
        write_reg(REG_CROSS_SQ, 23'h007FFF);
        write_reg(REG_PRESS_CUBE, 23'h008000);
        write_reg(REG_SCALE, 23'h7FFFFF);
        pending_samples.push_back('{24'sh7FFFFF, 24'sh7FFFFF});
        pending_samples.push_back('{24'sh800000, 24'sh800000});
        pending_samples.push_back('{24'sh000000, 24'sh000000});
        pending_samples.push_back('{24'sh000001, 24'shFFFFFF});
        drain();
        // Scale of one saturates both ways; scale of zero acts as one.
        write_reg(REG_SCALE, 23'd1);
        pending_samples.push_back('{24'sh7FFFFF, 24'sh000000});
        pending_samples.push_back('{24'sh800000, 24'sh000000});
        drain();
        write_reg(REG_SCALE, 23'd0);
        pending_samples.push_back('{24'sh000005, 24'sh000003});
        drain();
        // Ties: with scale 128 a unit linear term adds p/2, so odd p lands on a half.
        for (int i = 0; i < 7; i++)
            write_reg(cfg_reg_t'(i), '0);
        write_reg(REG_PRESS_LIN, 23'd1);
        write_reg(REG_SCALE, 23'd128);
        pending_samples.push_back('{24'sh000001, 24'sh000000});
        pending_samples.push_back('{24'shFFFFFF, 24'sh000000});
        pending_samples.push_back('{24'sh000003, 24'sh000000});
        drain();
        write_reg(REG_OFFSET, 23'hFFFFF);
        pending_samples.push_back('{24'sh000001, 24'sh000000});
        pending_samples.push_back('{24'shFFFFFD, 24'sh000000});
        drain();

        // Random phases with fresh register settings each.
        for (int ph = 0; ph < 8; ph++)
        begin
            for (int i = 0; i < 7; i++)
                write_reg(cfg_reg_t'(i), rand_coef(i < 2 ? 20 : 16));
            write_reg(REG_SCALE, rand_scale());
            idle_percent = idles[ph % 4];
            for (int n = 0; n < 85; n++)
                pending_samples.push_back('{rand_raw(), rand_raw()});
            drain();
        end

        $display("Checked %0d samples in, %0d results out, %0d saturated.",
                 transfers_in, transfers_out, sat_seen);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
